### hw/rtl/scc_pkg.sv
// Shared types and constants of the servo command conditioner.
// No dependencies; every other file of the block refers to this package.
package scc_pkg;

  localparam int JOINTS = 6;
  localparam int POS_W = 16;
  localparam int ANG_W = 12;
  localparam int PROD_W = 31;
  localparam int CFG_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // radians Q3.12 to 1/16 degree, Q16 factor (180/pi * 16 / 4096)
  localparam logic signed [POS_W-1:0] CONV_Q16 = 16'sd14668;
  localparam logic [ANG_W-1:0] RESET_ANGLE = 12'd1440;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ANGLE      = 3'd0,
    REG_MAX_ANGLE      = 3'd1,
    REG_DEADBAND       = 3'd2,
    REG_MODE_BITS      = 3'd3,
    REG_NEUTRAL_DELAY  = 3'd4,
    REG_OFFSETS        = 3'd5,
    REG_NEUTRAL        = 3'd6,
    REG_DIRECTION      = 3'd7
  } reg_idx_t;

  // mode_bits fields
  localparam int MODE_CHANGE_ONLY = 0;
  localparam int MODE_AUTO_NEUTRAL = 1;

  typedef struct packed {
    logic [ANG_W-1:0]             min_angle;
    logic [ANG_W-1:0]             max_angle;
    logic [7:0]                   deadband;
    logic [1:0]                   mode_bits;
    logic [31:0]                  neutral_delay;
    logic [JOINTS-1:0][7:0]       offsets;
    logic [JOINTS-1:0][7:0]       neutral;
    logic [JOINTS-1:0]            direction;
  } cfg_t;

  // one classified word between front and back
  typedef struct packed {
    logic                         func;
    logic [JOINTS-1:0]            present;
    logic [JOINTS-1:0][ANG_W-1:0] cmd;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic sent_once;
    logic timer_running;
  } back_status_t;

endpackage

### hw/rtl/scc_in_if.sv
// Input channel of the servo command conditioner: valid/ready plus sample word.
// Depends on scc_pkg for field widths.
interface scc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [scc_pkg::JOINTS-1:0]          present_mask;
  logic signed [scc_pkg::POS_W-1:0]    pos_0;
  logic signed [scc_pkg::POS_W-1:0]    pos_1;
  logic signed [scc_pkg::POS_W-1:0]    pos_2;
  logic signed [scc_pkg::POS_W-1:0]    pos_3;
  logic signed [scc_pkg::POS_W-1:0]    pos_4;
  logic signed [scc_pkg::POS_W-1:0]    pos_5;

  modport source (
    output valid, func, present_mask, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
    input  ready
  );
  modport sink (
    input  valid, func, present_mask, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
    output ready
  );
endinterface

### hw/rtl/scc_out_if.sv
// Result channel of the servo command conditioner: valid/ready plus command word.
// Depends on scc_pkg for field widths.
interface scc_out_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::ANG_W-1:0]     angle_0;
  logic [scc_pkg::ANG_W-1:0]     angle_1;
  logic [scc_pkg::ANG_W-1:0]     angle_2;
  logic [scc_pkg::ANG_W-1:0]     angle_3;
  logic [scc_pkg::ANG_W-1:0]     angle_4;
  logic [scc_pkg::ANG_W-1:0]     angle_5;
  logic                          from_timeout;

  modport source (
    output valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5, from_timeout,
    input  ready
  );
  modport sink (
    input  valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5, from_timeout,
    output ready
  );
endinterface

### hw/rtl/scc_front.sv
// Front end: accept sample words, scale each joint angle and clamp to limits.
// Depends on scc_pkg and scc_in_if; feeds scc_queue.
module scc_front (
  input  logic                clk,
  input  logic                rst_n,
  scc_in_if.sink              in_ch,
  input  scc_pkg::cfg_t       cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output scc_pkg::entry_t     push_data
);

  localparam int J = scc_pkg::JOINTS;

  logic                                   s1_v_r;
  logic                                   s1_func_r;
  logic [J-1:0]                           s1_present_r;
  logic signed [scc_pkg::PROD_W-1:0]      s1_prod_r   [J];
  logic signed [scc_pkg::PROD_W-1:0]      prod_nxt    [J];
  logic signed [scc_pkg::POS_W-1:0]       pos_a       [J];
  logic signed [31:0]                     term        [J];
  logic signed [31:0]                     total       [J];
  logic signed [16:0]                     val         [J];
  logic signed [16:0]                     lo          [J];
  logic signed [16:0]                     hi          [J];
  logic                                   advance;

  assign pos_a[0] = in_ch.pos_0;
  assign pos_a[1] = in_ch.pos_1;
  assign pos_a[2] = in_ch.pos_2;
  assign pos_a[3] = in_ch.pos_3;
  assign pos_a[4] = in_ch.pos_4;
  assign pos_a[5] = in_ch.pos_5;

  assign advance     = !s1_v_r || push_ready;
  assign in_ch.ready = advance;
  assign push_valid  = s1_v_r;

  always_comb begin
    for (int j = 0; j < J; j++) begin
      prod_nxt[j] = scc_pkg::PROD_W'(pos_a[j]) * scc_pkg::PROD_W'(scc_pkg::CONV_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_ch.valid;
    end
    if (advance && in_ch.valid) begin
      s1_func_r    <= in_ch.func;
      s1_present_r <= in_ch.present_mask;
      for (int j = 0; j < J; j++) begin
        s1_prod_r[j] <= prod_nxt[j];
      end
    end
  end

  // offset*16 in Q16, plus or minus the scaled angle, round half up, clamp
  always_comb begin
    push_data.func    = s1_func_r;
    push_data.present = s1_present_r;
    for (int j = 0; j < J; j++) begin
      term[j]  = cfg.direction[j] ? -32'(s1_prod_r[j]) : 32'(s1_prod_r[j]);
      total[j] = $signed({4'b0, cfg.offsets[j], 20'b0}) + term[j] + 32'sd32768;
      val[j]   = {total[j][31], total[j][31:16]};
      lo[j]    = $signed({5'b0, cfg.min_angle});
      hi[j]    = $signed({5'b0, cfg.max_angle});
      if (val[j] < lo[j]) begin
        push_data.cmd[j] = cfg.min_angle;
      end else if (val[j] > hi[j]) begin
        push_data.cmd[j] = cfg.max_angle;
      end else begin
        push_data.cmd[j] = val[j][scc_pkg::ANG_W-1:0];
      end
    end
  end

endmodule

### hw/rtl/scc_queue.sv
// Short word queue that decouples the front end from the back end.
// Depends on scc_pkg for the entry type and depth.
module scc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  scc_pkg::entry_t     push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output scc_pkg::entry_t     pop_data,
  output scc_pkg::q_status_t  status
);

  localparam int D = scc_pkg::QDEPTH;
  localparam int PW = scc_pkg::QPTR_W;
  localparam int CW = scc_pkg::QCNT_W;

  scc_pkg::entry_t  slot_r [D];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready   = cnt_r != CW'(D);
  assign pop_valid    = cnt_r != '0;
  assign pop_data     = slot_r[rp_r];
  assign status.count = cnt_r;
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(D - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(D - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

### hw/rtl/scc_back.sv
// Back end: change detection, last-sent state, neutral timer and result register.
// Depends on scc_pkg and scc_out_if; drains scc_queue.
module scc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scc_pkg::cfg_t         cfg,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  scc_pkg::entry_t       pop_data,
  scc_out_if.source             out_ch,
  output scc_pkg::back_status_t status
);

  localparam int J = scc_pkg::JOINTS;
  localparam int AW = scc_pkg::ANG_W;

  logic [J-1:0][AW-1:0] last_r, last_nxt;
  logic                 sent_once_r, sent_once_nxt;
  logic                 timer_r, timer_nxt;
  logic [31:0]          tick_r, tick_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [J-1:0][AW-1:0] out_ang_r, out_ang_nxt;
  logic                 out_to_r, out_to_nxt;

  logic [J-1:0][AW-1:0] cmd;
  logic [J-1:0][AW-1:0] neut16;
  logic [AW-1:0]        dl    [J];
  logic [AW-1:0]        dn    [J];
  logic                 changed, at_neutral, do_pop;
  logic [31:0]          tick_inc;

  assign pop_ready = !out_v_r || out_ch.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign tick_inc  = tick_r + 32'd1;

  always_comb begin
    changed    = !sent_once_r;
    at_neutral = 1'b1;
    for (int j = 0; j < J; j++) begin
      neut16[j] = {cfg.neutral[j], 4'b0};
      cmd[j]    = pop_data.present[j] ? pop_data.cmd[j] : last_r[j];
      dl[j]     = (cmd[j] > last_r[j]) ? cmd[j] - last_r[j] : last_r[j] - cmd[j];
      dn[j]     = (cmd[j] > neut16[j]) ? cmd[j] - neut16[j] : neut16[j] - cmd[j];
      if (dl[j] > {4'b0, cfg.deadband}) begin
        changed = 1'b1;
      end
      if (dn[j] > {4'b0, cfg.deadband}) begin
        at_neutral = 1'b0;
      end
    end
  end

  always_comb begin
    last_nxt      = last_r;
    sent_once_nxt = sent_once_r;
    timer_nxt     = timer_r;
    tick_nxt      = tick_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_ang_nxt   = out_ang_r;
    out_to_nxt    = out_to_r;
    if (do_pop) begin
      if (pop_data.func) begin
        // timer tick: expire once, then send neutral when auto return is on
        if (timer_r) begin
          tick_nxt = tick_inc;
          if (!(tick_inc < cfg.neutral_delay)) begin
            timer_nxt = 1'b0;
            if (cfg.mode_bits[scc_pkg::MODE_AUTO_NEUTRAL]) begin
              out_v_nxt   = 1'b1;
              out_ang_nxt = neut16;
              out_to_nxt  = 1'b1;
            end
          end
        end
      end else if (!cfg.mode_bits[scc_pkg::MODE_CHANGE_ONLY] || changed) begin
        last_nxt      = cmd;
        sent_once_nxt = 1'b1;
        out_v_nxt     = 1'b1;
        out_ang_nxt   = cmd;
        out_to_nxt    = 1'b0;
        if (cfg.mode_bits[scc_pkg::MODE_AUTO_NEUTRAL]) begin
          if (at_neutral) begin
            timer_nxt = 1'b0;
          end else begin
            timer_nxt = 1'b1;
            tick_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < J; j++) begin
        last_r[j] <= scc_pkg::RESET_ANGLE;
      end
      sent_once_r <= 1'b0;
      timer_r     <= 1'b0;
      tick_r      <= '0;
      out_v_r     <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      sent_once_r <= sent_once_nxt;
      timer_r     <= timer_nxt;
      tick_r      <= tick_nxt;
      out_v_r     <= out_v_nxt;
    end
    out_ang_r <= out_ang_nxt;
    out_to_r  <= out_to_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.angle_0      = out_ang_r[0];
  assign out_ch.angle_1      = out_ang_r[1];
  assign out_ch.angle_2      = out_ang_r[2];
  assign out_ch.angle_3      = out_ang_r[3];
  assign out_ch.angle_4      = out_ang_r[4];
  assign out_ch.angle_5      = out_ang_r[5];
  assign out_ch.from_timeout = out_to_r;

  assign status.sent_once     = sent_once_r;
  assign status.timer_running = timer_r;

endmodule

### hw/rtl/servo_command_conditioner_unit.sv
// Servo command conditioner: joint samples in radians to servo commands.
// Uses scc_pkg, scc_in_if, scc_out_if, scc_front, scc_queue and scc_back.
//
// Channels: in_ch carries one word per cycle while in_ch.ready is high, either a joint sample set
// (func 0: present mask plus six Q3.12 angles) or one timer tick (func 1).
// out_ch carries at most one command set per input word: six commands in
// 1/16 degree plus from_timeout, set for the automatic neutral set.
// cfg_we/cfg_idx/cfg_wdata write the eight settings; write only while idle.
//
// Throughput: one word per cycle, sustained, while out_ch is ready.
// The result becomes valid once the word has passed the front multiply
// register, the two-entry queue and the back result register. The loop
// that sets the pace is the back end's update of last-sent commands and
// the neutral tick counter.
//
// Reset (synchronous, rst_n low): settings take their defaults, last-sent
// commands go to ninety degrees, the timer stops, queue and pipe empty.
// Stall: a result waits in the output register; behind it the queue fills,
// then the front register holds and in_ch.ready drops. Nothing is dropped.
module servo_command_conditioner_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  scc_in_if.sink                            in_ch,
  scc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [scc_pkg::CFG_W-1:0]         cfg_wdata
);

  scc_pkg::cfg_t         cfg_r, cfg_nxt;
  scc_pkg::entry_t       push_data, pop_data;
  logic                  push_valid, push_ready;
  logic                  pop_valid, pop_ready;
  scc_pkg::q_status_t    q_st;
  scc_pkg::back_status_t b_st;

  // Settings: decode the index and take the low bits of the write data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (scc_pkg::reg_idx_t'(cfg_idx))
        scc_pkg::REG_MIN_ANGLE:     cfg_nxt.min_angle     = cfg_wdata[scc_pkg::ANG_W-1:0];
        scc_pkg::REG_MAX_ANGLE:     cfg_nxt.max_angle     = cfg_wdata[scc_pkg::ANG_W-1:0];
        scc_pkg::REG_DEADBAND:      cfg_nxt.deadband      = cfg_wdata[7:0];
        scc_pkg::REG_MODE_BITS:     cfg_nxt.mode_bits     = cfg_wdata[1:0];
        scc_pkg::REG_NEUTRAL_DELAY: cfg_nxt.neutral_delay = cfg_wdata[31:0];
        scc_pkg::REG_OFFSETS:       cfg_nxt.offsets       = cfg_wdata[scc_pkg::JOINTS*8-1:0];
        scc_pkg::REG_NEUTRAL:       cfg_nxt.neutral       = cfg_wdata[scc_pkg::JOINTS*8-1:0];
        scc_pkg::REG_DIRECTION:     cfg_nxt.direction     = cfg_wdata[scc_pkg::JOINTS-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_angle     <= 12'd0;
      cfg_r.max_angle     <= 12'd2880;
      cfg_r.deadband      <= 8'd2;
      cfg_r.mode_bits     <= 2'd3;
      cfg_r.neutral_delay <= 32'd2000;
      cfg_r.offsets       <= 48'h5A5A_5A5A_5A5A;   // ninety degrees per joint
      cfg_r.neutral       <= 48'h5A5A_5A5A_5A5A;
      cfg_r.direction     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept, scale, clamp; one register stage after the multipliers.
  scc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: absorb a stall of the back end until its two entries are full, then the front halts.
  scc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .status     (q_st)
  );

  // Back: hold missing joints, detect change, run the neutral timer, send.
  scc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch),
    .status    (b_st)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_sample_sets_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.from_timeout |-> b_st.sent_once)
    else $error("sample result without first-send flag");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.count <= scc_pkg::QCNT_W'(scc_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
